/* sv/range_min_query_tree_macros.svh */
// assertion helpers for the range minimum tree
`ifndef RANGE_MIN_QUERY_TREE_MACROS_SVH
`define RANGE_MIN_QUERY_TREE_MACROS_SVH

// same-cycle implication, checked out of reset
`define RMQ_ASSERT_IMP(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define RMQ_ASSERT_NXT(label, cond, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (prop)) \
    else $error(msg);

`endif

/* sv/rmq_pkg.sv */
package rmq_pkg;

  localparam int unsigned LEAF_BITS = 10;
  localparam int unsigned LEAVES    = 2 ** LEAF_BITS;
  // node address: 1-based heap position, root at 1, leaf i at LEAVES + i
  localparam int unsigned NODE_AW   = LEAF_BITS + 1;
  localparam int unsigned NODE_SLOTS = 2 ** NODE_AW;
  // query bounds run up to 2 * LEAVES
  localparam int unsigned POS_W     = NODE_AW + 1;
  localparam int unsigned WORD_W    = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  localparam word_t IDENTITY = {1'b0, {(WORD_W-1){1'b1}}};

  typedef enum logic [1:0] {
    FN_UPDATE = 2'd0,
    FN_QUERY  = 2'd1,
    FN_READ   = 2'd2
  } func_e;

  typedef struct packed {
    logic               we;
    logic [NODE_AW-1:0] waddr;
    word_t              wdata;
    logic [NODE_AW-1:0] raddr_a;
    logic [NODE_AW-1:0] raddr_b;
  } ram_req_t;

endpackage

/* sv/rmq_node_ram.sv */
module rmq_node_ram (
  input  logic              clk_i,
  input  rmq_pkg::ram_req_t req_i,
  output rmq_pkg::word_t    rd_a_o,
  output rmq_pkg::word_t    rd_b_o
);
  import rmq_pkg::*;

  word_t mem [NODE_SLOTS];
  word_t rd_a_q;
  word_t rd_b_q;

  // one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
    rd_a_q <= mem[req_i.raddr_a];
    rd_b_q <= mem[req_i.raddr_b];
  end

  assign rd_a_o = rd_a_q;
  assign rd_b_o = rd_b_q;

endmodule

/* sv/range_min_query_tree.sv */
// throughput: one word at a time; busy stays high until the result strobe, set by
// the one-node-per-level walk and the single write port of the node memory
// reset: a clearing pass fills every node with the identity;
// busy is high throughout and no start is taken
// results show for one cycle on done_o; the receiver cannot stall
module range_min_query_tree (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [1:0]                    func_i,
  input  logic [rmq_pkg::LEAF_BITS-1:0] index_i,
  input  rmq_pkg::word_t                new_value_i,
  input  logic [rmq_pkg::NODE_AW-1:0]   range_start_i,
  input  logic [rmq_pkg::NODE_AW-1:0]   range_end_i,
  output logic                          done_o,
  output rmq_pkg::word_t                answer_o,
  output logic                          bad_index_o
);
  import rmq_pkg::*;
  `include "range_min_query_tree_macros.svh"

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_UPD,
    S_QRY,
    S_DRAIN,
    S_READ
  } state_e;

  state_e             state_q;
  logic [NODE_AW-1:0] clr_q;
  logic [NODE_AW-1:0] pos_q;      // node last written on the update path
  word_t              cur_q;      // value held at pos_q
  word_t              val_q;      // value written on update, returned as answer
  logic [POS_W-1:0]   lo_q;
  logic [POS_W-1:0]   hi_q;
  logic               take_a_q;   // fold the read port a word this cycle
  logic               take_b_q;
  word_t              acc_q;
  logic               bad_q;
  logic               use_ram_q;  // point read answers from the node memory
  word_t              fix_q;      // constant answer otherwise
  logic               done_q;
  word_t              answer_q;
  logic               bad_index_q;

  ram_req_t           ram_req;
  word_t              rd_a;
  word_t              rd_b;

  logic               accept;
  logic               index_ok;
  logic [NODE_AW-1:0] leaf_addr;
  logic [NODE_AW-1:0] up_pos;
  word_t              up_min;
  logic [NODE_AW-1:0] qa;
  logic [NODE_AW-1:0] qb;
  logic               range_bad;
  logic [POS_W-1:0]   lo_next;
  logic [POS_W-1:0]   hi_next;
  word_t              fold_a;
  word_t              fold_b;
  word_t              fold_ab;
  word_t              acc_fold;

  assign accept    = start && (state_q == S_IDLE);
  assign busy      = (state_q != S_IDLE);
  assign index_ok  = ({1'b0, index_i} < NODE_AW'(LEAVES));
  assign leaf_addr = NODE_AW'(LEAVES) | NODE_AW'(index_i);

  // update walk: combine the node with its sibling and step to the parent
  assign up_pos = pos_q >> 1;
  assign up_min = (cur_q < rd_a) ? cur_q : rd_a;

  // query bounds clipped to the leaves
  assign qa = (range_start_i > NODE_AW'(LEAVES)) ? NODE_AW'(LEAVES) : range_start_i;
  assign qb = (range_end_i > NODE_AW'(LEAVES)) ? NODE_AW'(LEAVES) : range_end_i;
  assign range_bad = (range_start_i > NODE_AW'(LEAVES)) || (range_end_i > NODE_AW'(LEAVES));

  // bottom-up step: an odd left bound or odd right bound takes a node
  assign lo_next = (lo_q + POS_W'(lo_q[0])) >> 1;
  assign hi_next = (hi_q - POS_W'(hi_q[0])) >> 1;

  // fold the nodes read in the previous cycle into the running minimum
  assign fold_a   = take_a_q ? rd_a : IDENTITY;
  assign fold_b   = take_b_q ? rd_b : IDENTITY;
  assign fold_ab  = (fold_a < fold_b) ? fold_a : fold_b;
  assign acc_fold = (acc_q < fold_ab) ? acc_q : fold_ab;

  // node memory port requests
  always_comb begin
    ram_req         = '0;
    ram_req.wdata   = IDENTITY;
    unique case (state_q)
      S_CLEAR: begin
        ram_req.we    = 1'b1;
        ram_req.waddr = clr_q;
      end
      S_IDLE: begin
        if (accept && index_ok && (func_i == FN_UPDATE)) begin
          ram_req.we      = 1'b1;
          ram_req.waddr   = leaf_addr;
          ram_req.wdata   = new_value_i;
          ram_req.raddr_a = leaf_addr ^ NODE_AW'(1);
        end else begin
          ram_req.raddr_a = leaf_addr;
        end
      end
      S_UPD: begin
        ram_req.we      = 1'b1;
        ram_req.waddr   = up_pos;
        ram_req.wdata   = up_min;
        ram_req.raddr_a = up_pos ^ NODE_AW'(1);
      end
      S_QRY: begin
        ram_req.raddr_a = lo_q[NODE_AW-1:0];
        ram_req.raddr_b = NODE_AW'(hi_q - POS_W'(1));
      end
      default: begin
      end
    endcase
  end

  rmq_node_ram u_ram (
    .clk_i  (clk_i),
    .req_i  (ram_req),
    .rd_a_o (rd_a),
    .rd_b_o (rd_b)
  );

  // sequencer with registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      done_q   <= 1'b0;
      take_a_q <= 1'b0;
      take_b_q <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      take_a_q <= 1'b0;
      take_b_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + NODE_AW'(1);
          if (clr_q == {NODE_AW{1'b1}}) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            bad_q     <= 1'b0;
            use_ram_q <= 1'b0;
            fix_q     <= '0;
            acc_q     <= IDENTITY;
            state_q   <= S_READ;
            case (func_i)
              FN_UPDATE: begin
                if (index_ok) begin
                  pos_q   <= leaf_addr;
                  cur_q   <= new_value_i;
                  val_q   <= new_value_i;
                  state_q <= S_UPD;
                end else begin
                  bad_q <= 1'b1;
                end
              end
              FN_QUERY: begin
                bad_q <= range_bad;
                if (qa >= qb) begin
                  fix_q <= IDENTITY;
                end else begin
                  lo_q    <= POS_W'(qa) + POS_W'(LEAVES);
                  hi_q    <= POS_W'(qb) + POS_W'(LEAVES);
                  state_q <= S_QRY;
                end
              end
              FN_READ: begin
                use_ram_q <= index_ok;
                bad_q     <= !index_ok;
              end
              default: begin
                // unused code answers zero
              end
            endcase
          end
        end
        S_UPD: begin
          pos_q <= up_pos;
          cur_q <= up_min;
          if (up_pos == NODE_AW'(1)) begin
            done_q      <= 1'b1;
            answer_q    <= val_q;
            bad_index_q <= 1'b0;
            state_q     <= S_IDLE;
          end
        end
        S_QRY: begin
          acc_q    <= acc_fold;
          take_a_q <= lo_q[0];
          take_b_q <= hi_q[0];
          lo_q     <= lo_next;
          hi_q     <= hi_next;
          if (lo_next >= hi_next) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          done_q      <= 1'b1;
          answer_q    <= acc_fold;
          bad_index_q <= bad_q;
          state_q     <= S_IDLE;
        end
        S_READ: begin
          done_q      <= 1'b1;
          answer_q    <= use_ram_q ? rd_a : fix_q;
          bad_index_q <= bad_q;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign done_o      = done_q;
  assign answer_o    = answer_q;
  assign bad_index_o = bad_index_q;

  `RMQ_ASSERT_NXT(a_accept_busy, accept, busy, "accepted word did not make the block busy")
  `RMQ_ASSERT_IMP(a_done_idle, done_o, !busy, "result strobe while still busy")
  `RMQ_ASSERT_NXT(a_done_pulse, done_o, !done_o, "result strobe longer than one cycle")
  `RMQ_ASSERT_IMP(a_qry_order, state_q == S_QRY, lo_q < hi_q, "query bounds crossed in walk")

endmodule
